// ===== hdl/hashed_event_table_macros.svh =====
// Assertion macros for the hashed event table.
// Included by the RTL files that carry concurrent checks; needs clk and rst in scope.
`ifndef HASHED_EVENT_TABLE_MACROS_SVH
`define HASHED_EVENT_TABLE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define HET_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hashed_event_table: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define HET_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hashed_event_table: next-cycle check failed");
`else
`define HET_ASSERT_IMP(label, ante, cons)
`define HET_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== hdl/het_pkg.sv =====
// Shared types, codes and hash helpers of the hashed event table.
// No dependencies; imported by het_hash, hashed_event_table and the testbench.
package het_pkg;

  typedef enum logic [3:0] {
    REQ_LOOKUP     = 4'd0,
    REQ_WRITE_KEY  = 4'd1,
    REQ_CLEAR_SLOT = 4'd2,
    REQ_FIND_FREE  = 4'd3,
    REQ_FIND_EV    = 4'd4,
    REQ_READ_EV    = 4'd5,
    REQ_WRITE_EV   = 4'd6,
    REQ_READ_HASH  = 4'd7,
    REQ_COUNT      = 4'd8,
    REQ_CLEAR_HASH = 4'd9
  } het_req_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_BAD_ARG   = 2'd2
  } het_status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } het_state_t;

  localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  hash;
  } het_entry_t;

  function automatic logic [7:0] het_fold(input logic [15:0] v);
    return v[7:0] ^ v[15:8];
  endfunction

  // 7 * fold(nn) + fold(en), kept to eight bits.
  function automatic logic [7:0] het_pre_hash(input logic [15:0] nn, input logic [15:0] en);
    logic [10:0] sum;
    sum = 11'd7 * {3'b000, het_fold(nn)} + {3'b000, het_fold(en)};
    return sum[7:0];
  endfunction

endpackage

// ===== hdl/het_hash.sv =====
// Key hash of the hashed event table: fold, weighted sum and reduction table.
// Uses het_pkg for the fold helpers and the empty key constant.
module het_hash import het_pkg::*; #(
  parameter int HASH_SLOTS = 128
) (
  input  logic [31:0] key,
  output logic [7:0]  key_hash,
  output logic [7:0]  slot_hash
);

  logic [7:0] mod_tab [256];
  logic [7:0] pre;

  // Reduction modulo the hash table size, with a zero remainder mapped to 255.
  for (genvar g = 0; g < 256; g++) begin : g_tab
    localparam int Rem = g % HASH_SLOTS;
    assign mod_tab[g] = (Rem == 0) ? 8'd255 : 8'(Rem);
  end

  assign pre       = het_pre_hash(key[31:16], key[15:0]);
  assign key_hash  = mod_tab[pre];
  assign slot_hash = (key == EMPTY_KEY) ? 8'd0 : key_hash;

endmodule

// ===== hdl/hashed_event_table.sv =====
// Hashed event table top level: slot entry memory, event variable memory and sequencer.
// Lookup, find free, find by variable and count scan one slot per cycle, ending at a match
// or the last slot. Key and variable writes and clears go straight to the result, reads pass
// through ST_READ. After reset a clearing pass writes all ones into the variable memory, one
// entry per cycle over all SLOTS << VAR_AW entries (512 by default); no item is taken then.
`include "hashed_event_table_macros.svh"
module hashed_event_table import het_pkg::*; #(
  parameter int SLOTS         = 64,
  parameter int VARS_PER_SLOT = 8,
  parameter int HASH_SLOTS    = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [3:0]  req_type,
  input  logic [5:0]  slot,
  input  logic [15:0] node_number,
  input  logic [15:0] event_number,
  input  logic [3:0]  var_number,
  input  logic [7:0]  var_value,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [6:0]  found_slot,
  output logic [1:0]  status,
  output logic [7:0]  hash_out,
  output logic [7:0]  var_out,
  output logic [6:0]  occupied_count
);

  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int VAR_AW  = (VARS_PER_SLOT > 1) ? $clog2(VARS_PER_SLOT) : 1;
  localparam int VADDR_W = SLOT_AW + VAR_AW;
  localparam int VDEPTH  = SLOTS << VAR_AW;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  het_state_t state, state_next;

  // Memories.
  het_entry_t ent_mem [SLOTS];
  logic [7:0] var_mem [VDEPTH];
  het_entry_t ent_rd;
  logic [7:0] var_rd;
  logic [SLOTS-1:0] occ;

  // Captured request.
  het_req_t          op;
  logic [31:0]       key_q;
  logic [7:0]        h_q;
  logic [VAR_AW-1:0] vidx_q;
  logic [7:0]        vv_q;

  // Scan control.
  logic [CNT_W-1:0]   idx;
  logic               cmp_vld;
  logic [SLOT_AW-1:0] cmp_idx;
  logic               cmp_occ;
  logic               issue;
  logic               scan_match;
  logic               cmp_last;

  // Working result.
  logic [6:0]       r_found;
  het_status_t      r_status;
  logic [7:0]       r_hout;
  logic [7:0]       r_vout;
  logic [CNT_W-1:0] r_cnt;

  logic              acc;
  logic              slot_ok;
  logic              var_ok;
  het_status_t       acc_status;
  logic              wr_ent;
  logic              wr_var;
  logic [31:0]       wr_key;
  logic [7:0]        key_hash;
  logic [7:0]        slot_hash;
  logic [VADDR_W-1:0] init_addr;
  logic [SLOT_AW-1:0] slot_a;
  logic [VAR_AW-1:0]  vidx_in;
  logic [SLOT_AW-1:0] ent_raddr;
  logic [VADDR_W-1:0] var_raddr;
  logic [VADDR_W-1:0] var_waddr;
  logic [7:0]         var_wdata;
  logic               var_we;
  logic               res_free;

  assign req_stall = (state != ST_IDLE);
  assign acc       = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;

  assign slot_ok = ({3'b000, slot} < 9'(SLOTS));
  assign var_ok  = (var_number != 4'd0) && ({1'b0, var_number} <= 5'(VARS_PER_SLOT));
  assign slot_a  = SLOT_AW'(slot);
  assign vidx_in = VAR_AW'(var_number - 4'd1);

  assign wr_key = (req_type == REQ_CLEAR_SLOT) ? EMPTY_KEY : {node_number, event_number};
  assign wr_ent = acc && slot_ok && (req_type == REQ_WRITE_KEY || req_type == REQ_CLEAR_SLOT);
  assign wr_var = acc && slot_ok && var_ok && (req_type == REQ_WRITE_EV);

  het_hash #(
    .HASH_SLOTS(HASH_SLOTS)
  ) u_hash (
    .key      (wr_key),
    .key_hash (key_hash),
    .slot_hash(slot_hash)
  );

  // Read addresses come from the request while idle and from the scan counter otherwise.
  assign ent_raddr = (state == ST_IDLE) ? slot_a : idx[SLOT_AW-1:0];
  assign var_raddr = (state == ST_IDLE) ? {slot_a, vidx_in} : {idx[SLOT_AW-1:0], vidx_q};

  assign var_we    = (state == ST_INIT) || wr_var;
  assign var_waddr = (state == ST_INIT) ? init_addr : {slot_a, vidx_in};
  assign var_wdata = (state == ST_INIT) ? 8'hFF : var_value;

  always_ff @(posedge clk) begin
    if (wr_ent) begin
      ent_mem[slot_a] <= '{key: wr_key, hash: slot_hash};
    end
    ent_rd <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (var_we) begin
      var_mem[var_waddr] <= var_wdata;
    end
    var_rd <= var_mem[var_raddr];
  end

  assign cmp_last = (cmp_idx == SLOT_AW'(SLOTS - 1));

  always_comb begin
    case (op)
      REQ_LOOKUP:    scan_match = cmp_occ && (ent_rd.key == key_q) && (ent_rd.hash == h_q);
      REQ_FIND_FREE: scan_match = !cmp_occ;
      REQ_FIND_EV:   scan_match = (var_rd == vv_q);
      default:       scan_match = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    case (req_type)
      REQ_LOOKUP, REQ_FIND_FREE:               acc_status = STS_NOT_FOUND;
      REQ_WRITE_KEY, REQ_CLEAR_SLOT,
      REQ_READ_HASH:                           acc_status = slot_ok ? STS_OK : STS_BAD_ARG;
      REQ_FIND_EV:                             acc_status = var_ok ? STS_NOT_FOUND : STS_BAD_ARG;
      REQ_READ_EV, REQ_WRITE_EV:
        acc_status = (slot_ok && var_ok) ? STS_OK : STS_BAD_ARG;
      REQ_COUNT, REQ_CLEAR_HASH:               acc_status = STS_OK;
      default:                                 acc_status = STS_BAD_ARG;
    endcase
    case (state)
      ST_INIT: begin
        if (init_addr == VADDR_W'(VDEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          case (req_type)
            REQ_LOOKUP, REQ_FIND_FREE, REQ_COUNT: state_next = ST_SCAN;
            REQ_FIND_EV:   state_next = var_ok ? ST_SCAN : ST_DONE;
            REQ_READ_EV:   state_next = (slot_ok && var_ok) ? ST_READ : ST_DONE;
            REQ_READ_HASH: state_next = slot_ok ? ST_READ : ST_DONE;
            default:       state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        issue = (idx != CNT_W'(SLOTS));
        if (cmp_vld && (scan_match || cmp_last)) state_next = ST_DONE;
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (res_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      init_addr <= '0;
      occ       <= '0;
      cmp_vld   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= issue;
      if (state == ST_INIT) init_addr <= init_addr + VADDR_W'(1);
      if (wr_ent) occ[slot_a] <= (slot_hash != 8'd0);
      if (acc && req_type == REQ_CLEAR_HASH) occ <= '0;
      if (state == ST_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= idx[SLOT_AW-1:0];
    cmp_occ <= occ[ent_raddr];
    if (acc) begin
      op       <= het_req_t'(req_type);
      key_q    <= {node_number, event_number};
      h_q      <= key_hash;
      vidx_q   <= vidx_in;
      vv_q     <= var_value;
      idx      <= '0;
      r_found  <= 7'(SLOTS);
      r_status <= acc_status;
      r_hout   <= wr_ent ? slot_hash : 8'd0;
      r_vout   <= 8'd0;
      r_cnt    <= '0;
    end
    if (issue) idx <= idx + CNT_W'(1);
    if (state == ST_SCAN && cmp_vld) begin
      if (op == REQ_COUNT) r_cnt <= r_cnt + CNT_W'(cmp_occ);
      if (scan_match) begin
        r_found  <= 7'(cmp_idx);
        r_status <= STS_OK;
      end
    end
    if (state == ST_READ) begin
      if (op == REQ_READ_EV) r_vout <= var_rd;
      if (op == REQ_READ_HASH) r_hout <= cmp_occ ? ent_rd.hash : 8'd0;
    end
    if (state == ST_DONE && res_free) begin
      found_slot     <= r_found;
      status         <= r_status;
      hash_out       <= r_hout;
      var_out        <= r_vout;
      occupied_count <= 7'(r_cnt);
    end
  end

  `HET_ASSERT_IMP(a_scan_bound, state == ST_SCAN, idx <= CNT_W'(SLOTS))
  `HET_ASSERT_NXT(a_clear_hashes, acc && req_type == REQ_CLEAR_HASH, occ == '0)
  `HET_ASSERT_IMP(a_miss_none, res_valid && status == STS_NOT_FOUND, found_slot == 7'(SLOTS))
  `HET_ASSERT_IMP(a_bad_quiet, res_valid && status == STS_BAD_ARG, ~|{hash_out, var_out, occupied_count})

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for hashed_event_table: directed and random requests, idle/stall phases.
// Depends on het_pkg and the hashed_event_table RTL; keeps its own copy of the table contents.
module testbench import het_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS            = 64;
  localparam int VARS_PER_SLOT    = 8;
  localparam int HASH_SLOTS       = 128;
  localparam int FIRST_UNUSED_REQ = 10;
  localparam int LAST_REQ_CODE    = 15;
  localparam int POOL_SIZE        = 12;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  slot;
    logic [15:0] nn;
    logic [15:0] en;
    logic [3:0]  vn;
    logic [7:0]  vv;
    bit   [6:0]  send_idle;
    bit   [6:0]  recv_stall;
    bit          drain;
  } table_req_t;

  typedef struct packed {
    logic [6:0] found;
    logic [1:0] status;
    logic [7:0] hash;
    logic [7:0] value;
    logic [6:0] count;
  } table_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [3:0]  req_type = '0;
  logic [5:0]  slot = '0;
  logic [15:0] node_number = '0;
  logic [15:0] event_number = '0;
  logic [3:0]  var_number = '0;
  logic [7:0]  var_value = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [6:0]  found_slot;
  logic [1:0]  status;
  logic [7:0]  hash_out;
  logic [7:0]  var_out;
  logic [6:0]  occupied_count;

  hashed_event_table #(
    .SLOTS(SLOTS),
    .VARS_PER_SLOT(VARS_PER_SLOT),
    .HASH_SLOTS(HASH_SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .slot(slot),
    .node_number(node_number),
    .event_number(event_number),
    .var_number(var_number),
    .var_value(var_value),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .found_slot(found_slot),
    .status(status),
    .hash_out(hash_out),
    .var_out(var_out),
    .occupied_count(occupied_count)
  );

  // Shadow copy of the table contents.
  logic [31:0] key_mem  [SLOTS];
  logic [7:0]  hash_mem [SLOTS];
  logic [7:0]  var_mem  [SLOTS * VARS_PER_SLOT];

  table_req_t  request_backlog[$];
  table_resp_t outstanding_results[$];
  table_req_t  in_flight;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;

  int          gen_send_idle = 0;
  int          gen_recv_stall = 0;
  bit          gen_drain = 1'b0;
  logic [15:0] pool_nn [POOL_SIZE];
  logic [15:0] pool_en [POOL_SIZE];

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic note_mismatch(input string what);
    // Printing stops after the first hundred to keep the log readable.
    if (mismatch_count < 100)
      $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic logic [7:0] key_hash(input logic [15:0] nn, input logic [15:0] en);
    logic [7:0] fold_nn, fold_en, mix;
    int wrapped;
    fold_nn = nn[15:8] ^ nn[7:0];
    fold_en = en[15:8] ^ en[7:0];
    mix = fold_nn * 8'd7 + fold_en;
    wrapped = int'(mix) % HASH_SLOTS;
    return (wrapped == 0) ? 8'd255 : 8'(wrapped);
  endfunction

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic table_resp_t table_response(input table_req_t r);
    table_resp_t o;
    logic [31:0] key;
    logic [7:0]  h;
    bit          slot_ok, var_ok;
    int          idx;
    o.found  = 7'(SLOTS);
    o.status = STS_OK;
    o.hash   = '0;
    o.value  = '0;
    o.count  = '0;
    key      = {r.nn, r.en};
    slot_ok  = int'(r.slot) < SLOTS;
    var_ok   = r.vn >= 1 && int'(r.vn) <= VARS_PER_SLOT;
    idx      = int'(r.slot) * VARS_PER_SLOT + int'(r.vn) - 1;
    case (r.kind)
      REQ_LOOKUP: begin
        h = key_hash(r.nn, r.en);
        o.status = STS_NOT_FOUND;
        for (int i = 0; i < SLOTS; i++) begin
          if (o.status == STS_NOT_FOUND && hash_mem[i] == h && key_mem[i] == key) begin
            o.found  = 7'(i);
            o.status = STS_OK;
          end
        end
      end
      REQ_WRITE_KEY, REQ_CLEAR_SLOT: begin
        if (!slot_ok) begin
          o.status = STS_BAD_ARG;
        end else begin
          if (r.kind == REQ_CLEAR_SLOT)
            key = EMPTY_KEY;
          key_mem[r.slot]  = key;
          hash_mem[r.slot] = (key == EMPTY_KEY) ? 8'd0 : key_hash(key[31:16], key[15:0]);
          o.hash = hash_mem[r.slot];
        end
      end
      REQ_FIND_FREE: begin
        o.status = STS_NOT_FOUND;
        for (int i = 0; i < SLOTS; i++) begin
          if (o.status == STS_NOT_FOUND && hash_mem[i] == 8'd0) begin
            o.found  = 7'(i);
            o.status = STS_OK;
          end
        end
      end
      REQ_FIND_EV: begin
        if (!var_ok) begin
          o.status = STS_BAD_ARG;
        end else begin
          o.status = STS_NOT_FOUND;
          for (int i = 0; i < SLOTS; i++) begin
            if (o.status == STS_NOT_FOUND
                && var_mem[i * VARS_PER_SLOT + int'(r.vn) - 1] == r.vv) begin
              o.found  = 7'(i);
              o.status = STS_OK;
            end
          end
        end
      end
      REQ_READ_EV, REQ_WRITE_EV: begin
        if (!slot_ok || !var_ok)
          o.status = STS_BAD_ARG;
        else if (r.kind == REQ_WRITE_EV)
          var_mem[idx] = r.vv;
        else
          o.value = var_mem[idx];
      end
      REQ_READ_HASH: begin
        if (!slot_ok)
          o.status = STS_BAD_ARG;
        else
          o.hash = hash_mem[r.slot];
      end
      REQ_COUNT: begin
        for (int i = 0; i < SLOTS; i++)
          if (hash_mem[i] != 8'd0)
            o.count++;
      end
      REQ_CLEAR_HASH: begin
        for (int i = 0; i < SLOTS; i++)
          hash_mem[i] = 8'd0;
      end
      default: begin
        o.status = STS_BAD_ARG;
      end
    endcase
    return o;
  endfunction

  // Request side: the payload is held until accepted, and a draining item waits for
  // every outstanding result before it is offered.
  always @(posedge clk) begin : drive
    bit took;
    took = 1'b0;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        outstanding_results.push_back(table_response(in_flight));
        took = 1'b1;
      end
      if (!req_valid || took) begin
        if (request_backlog.size() != 0
            && !(request_backlog[0].drain && outstanding_results.size() != 0)
            && $urandom_range(99, 0) >= request_backlog[0].send_idle) begin
          in_flight = request_backlog.pop_front();
          recv_stall_pct = in_flight.recv_stall;
          req_type     <= in_flight.kind;
          slot         <= in_flight.slot;
          node_number  <= in_flight.nn;
          event_number <= in_flight.en;
          var_number   <= in_flight.vn;
          var_value    <= in_flight.vv;
          req_valid    <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : observe
    table_resp_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (outstanding_results.size() == 0) begin
          note_mismatch("result arrived with no request outstanding");
        end else begin
          want = outstanding_results.pop_front();
          if (found_slot !== want.found)
            note_mismatch($sformatf("found_slot %0d, expected %0d", found_slot, want.found));
          if (status !== want.status)
            note_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (hash_out !== want.hash)
            note_mismatch($sformatf("hash_out %0d, expected %0d", hash_out, want.hash));
          if (var_out !== want.value)
            note_mismatch($sformatf("var_out %0d, expected %0d", var_out, want.value));
          if (occupied_count !== want.count)
            note_mismatch($sformatf("occupied_count %0d, expected %0d",
                                    occupied_count, want.count));
        end
      end
      res_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  task automatic push_req(input logic [3:0] kind, input int s, input logic [15:0] nn,
                          input logic [15:0] en, input int vn, input int vv);
    table_req_t r;
    r.kind       = kind;
    r.slot       = 6'(s);
    r.nn         = nn;
    r.en         = en;
    r.vn         = 4'(vn);
    r.vv         = 8'(vv);
    r.send_idle  = 7'(gen_send_idle);
    r.recv_stall = 7'(gen_recv_stall);
    r.drain      = gen_drain;
    gen_drain    = 1'b0;
    request_backlog.push_back(r);
  endtask

  task automatic random_request();
    int roll, pick, s, vn, vv;
    logic [15:0] nn, en;
    roll = $urandom_range(99, 0);
    pick = $urandom_range(POOL_SIZE - 1, 0);
    s    = ($urandom_range(1, 0) == 1) ? $urandom_range(7, 0) : $urandom_range(SLOTS - 1, 0);
    vn   = ($urandom_range(99, 0) < 85) ? $urandom_range(VARS_PER_SLOT, 1)
                                         : $urandom_range(LAST_REQ_CODE, 0);
    vv   = ($urandom_range(1, 0) == 1) ? $urandom_range(7, 0) : $urandom_range(255, 0);
    nn   = ($urandom_range(99, 0) < 80) ? pool_nn[pick] : 16'($urandom);
    en   = ($urandom_range(99, 0) < 80) ? pool_en[pick] : 16'($urandom);
    if (roll < 25)
      push_req(REQ_LOOKUP, s, nn, en, vn, vv);
    else if (roll < 40) begin
      // An occasional all-ones key empties the slot it is written to.
      if ($urandom_range(19, 0) == 0)
        push_req(REQ_WRITE_KEY, s, 16'hFFFF, 16'hFFFF, vn, vv);
      else
        push_req(REQ_WRITE_KEY, s, nn, en, vn, vv);
    end
    else if (roll < 47) push_req(REQ_CLEAR_SLOT, s, nn, en, vn, vv);
    else if (roll < 53) push_req(REQ_FIND_FREE, s, nn, en, vn, vv);
    else if (roll < 63) push_req(REQ_FIND_EV, s, nn, en, vn, vv);
    else if (roll < 73) push_req(REQ_READ_EV, s, nn, en, vn, vv);
    else if (roll < 83) push_req(REQ_WRITE_EV, s, nn, en, vn, vv);
    else if (roll < 91) push_req(REQ_READ_HASH, s, nn, en, vn, vv);
    else if (roll < 96) push_req(REQ_COUNT, s, nn, en, vn, vv);
    else if (roll < 97) push_req(REQ_CLEAR_HASH, s, nn, en, vn, vv);
    else push_req(4'($urandom_range(LAST_REQ_CODE, FIRST_UNUSED_REQ)), s, nn, en, vn, vv);
  endtask

  initial begin
    logic [15:0] fill_nn, fill_en;
    foreach (key_mem[i]) begin
      key_mem[i]  = EMPTY_KEY;
      hash_mem[i] = 8'd0;
    end
    foreach (var_mem[i])
      var_mem[i] = 8'hFF;

    // Key pool: random keys in pairs of the same hash but another key; the first key is then set to zero.
    for (int i = 0; i < POOL_SIZE; i += 2) begin
      pool_nn[i]     = 16'($urandom);
      pool_en[i]     = 16'($urandom);
      pool_nn[i + 1] = pool_nn[i];
      pool_en[i + 1] = (i % 4 == 0) ? pool_en[i] ^ 16'h0101 : pool_en[i] ^ 16'h8000;
    end
    pool_nn[0] = 16'h0000;
    pool_en[0] = 16'h0000;

    // Directed part.
    push_req(REQ_COUNT, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_FIND_FREE, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_LOOKUP, 0, 16'h0000, 16'h0000, 1, 0);
    // A raw hash of zero becomes 255, both for zero and for a value equal to HASH_SLOTS.
    push_req(REQ_WRITE_KEY, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_WRITE_KEY, 63, 16'hFFFF, 16'hFFFE, 1, 0);
    push_req(REQ_WRITE_KEY, 1, 16'h0000, 16'h0080, 1, 0);
    push_req(REQ_WRITE_KEY, 2, 16'h1234, 16'h5678, 1, 0);
    push_req(REQ_WRITE_KEY, 3, 16'h1234, 16'h5779, 1, 0);
    push_req(REQ_LOOKUP, 0, 16'h1234, 16'h5779, 1, 0);
    push_req(REQ_LOOKUP, 0, 16'h0000, 16'h0080, 1, 0);
    push_req(REQ_WRITE_KEY, 5, 16'hFFFF, 16'hFFFF, 1, 0);
    push_req(REQ_READ_HASH, 5, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_READ_HASH, 63, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_CLEAR_SLOT, 2, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_LOOKUP, 0, 16'h1234, 16'h5678, 1, 0);
    push_req(REQ_FIND_FREE, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_WRITE_EV, 63, 16'h0000, 16'h0000, VARS_PER_SLOT, 8'h00);
    push_req(REQ_READ_EV, 63, 16'h0000, 16'h0000, VARS_PER_SLOT, 0);
    push_req(REQ_READ_EV, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_FIND_EV, 0, 16'h0000, 16'h0000, VARS_PER_SLOT, 8'h00);
    push_req(REQ_FIND_EV, 0, 16'h0000, 16'h0000, 1, 8'h55);
    push_req(REQ_FIND_EV, 0, 16'h0000, 16'h0000, 1, 8'hFF);
    push_req(REQ_READ_EV, 4, 16'h0000, 16'h0000, 0, 0);
    push_req(REQ_WRITE_EV, 4, 16'h0000, 16'h0000, VARS_PER_SLOT + 1, 8'hAA);
    push_req(REQ_FIND_EV, 0, 16'h0000, 16'h0000, LAST_REQ_CODE, 8'hFF);
    push_req(4'(FIRST_UNUSED_REQ), 0, 16'h0000, 16'h0000, 1, 0);
    push_req(4'(LAST_REQ_CODE), 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_COUNT, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_CLEAR_HASH, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_COUNT, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_LOOKUP, 0, 16'h0000, 16'h0000, 1, 0);

    // First random phase: no idling, and the table is filled to the last slot once.
    gen_drain = 1'b1;
    for (int s = 0; s < SLOTS; s++) begin
      fill_nn = 16'($urandom);
      fill_en = 16'($urandom);
      push_req(REQ_WRITE_KEY, s, fill_nn, fill_en, 1, 0);
    end
    push_req(REQ_FIND_FREE, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_COUNT, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_LOOKUP, 0, fill_nn, fill_en, 1, 0);
    push_req(REQ_CLEAR_HASH, 0, 16'h0000, 16'h0000, 1, 0);
    push_req(REQ_LOOKUP, 0, fill_nn, fill_en, 1, 0);
    repeat (50) random_request();

    gen_send_idle = 70;
    gen_recv_stall = 0;
    gen_drain = 1'b1;
    repeat (110) random_request();

    gen_send_idle = 0;
    gen_recv_stall = 70;
    gen_drain = 1'b1;
    repeat (110) random_request();

    gen_send_idle = 21;
    gen_recv_stall = 21;
    gen_drain = 1'b1;
    repeat (110) random_request();

    while (request_backlog.size() != 0 || req_valid || outstanding_results.size() != 0)
      @(posedge clk);
    repeat (SLOTS + 16) @(posedge clk);
    if (outstanding_results.size() != 0)
      note_mismatch("results still outstanding at the end");
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/het_pkg.sv
hdl/het_hash.sv
hdl/hashed_event_table.sv
bench/testbench.sv
